// ----- src/tmqt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmqt_pkg
// Shared sizes, codes and controller/datapath interface types of the typed
// message queue table.
// ----------------------------------------------------------------------------
package tmqt_pkg;

  localparam int NUM_QUEUES = 8;
  localparam int MSG_SLOTS  = 64;
  localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW         = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int AW         = QW + SW;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEND   = 2'd2;
  localparam logic [1:0] MODE_RECV   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXISTS     = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_NO_QUEUE   = 3'd3;
  localparam logic [2:0] ST_ZERO_TYPE  = 3'd4;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd5;
  localparam logic [2:0] ST_NO_MATCH   = 3'd6;

  typedef struct packed {
    logic signed [31:0] typ;
    logic [31:0]        data;
    logic [SW-1:0]      nxt;
  } slot_word_t;

  typedef struct packed {
    logic       load;
    logic       create;
    logic       del;
    logic       send_start;
    logic       recv_start;
    logic       scan_step;
    logic       slot_wr_new;
    logic       rd_tail;
    logic       tail_wr;
    logic       send_upd;
    logic       rcv_step;
    logic       rcv_hit;
    logic       set_st;
    logic [2:0] st;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       tbl_full;
    logic       type_zero;
    logic       q_full;
    logic       q_empty;
    logic       cur_empty;
    logic       bit_used;
    logic       last;
    logic       match;
    logic       out_free;
  } dp_sts_t;

endpackage

// ----- src/tmqt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmqt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmqt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic         clk,
  input  logic         we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic         re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/tmqt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmqt_ctrl
// Operation sequencer: decodes the word, steps the slot scan and list walk.
// ----------------------------------------------------------------------------
module tmqt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tmqt_pkg::dp_sts_t sts,
  output tmqt_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_SSCAN = 4'd2;
  localparam logic [3:0] S_SWR   = 4'd3;
  localparam logic [3:0] S_STRD  = 4'd4;
  localparam logic [3:0] S_SUPD  = 4'd5;
  localparam logic [3:0] S_RCHK  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.set_st = 1'b1;
        cmd.st     = tmqt_pkg::ST_OK;
        state_nxt  = S_FIN;
        unique case (sts.mode)
          tmqt_pkg::MODE_CREATE: begin
            priority if (sts.hit) cmd.st = tmqt_pkg::ST_EXISTS;
            else if (sts.tbl_full) cmd.st = tmqt_pkg::ST_TABLE_FULL;
            else cmd.create = 1'b1;
          end
          tmqt_pkg::MODE_DELETE: begin
            if (!sts.hit) cmd.st = tmqt_pkg::ST_NO_QUEUE;
            else cmd.del = 1'b1;
          end
          tmqt_pkg::MODE_SEND: begin
            priority if (sts.type_zero) cmd.st = tmqt_pkg::ST_ZERO_TYPE;
            else if (!sts.hit) cmd.st = tmqt_pkg::ST_NO_QUEUE;
            else if (sts.q_full) cmd.st = tmqt_pkg::ST_QUEUE_FULL;
            else begin
              cmd.set_st     = 1'b0;
              cmd.send_start = 1'b1;
              state_nxt      = S_SSCAN;
            end
          end
          tmqt_pkg::MODE_RECV: begin
            priority if (!sts.hit) cmd.st = tmqt_pkg::ST_NO_QUEUE;
            else if (sts.q_empty) cmd.st = tmqt_pkg::ST_NO_MATCH;
            else begin
              cmd.set_st     = 1'b0;
              cmd.recv_start = 1'b1;
              state_nxt      = S_RCHK;
            end
          end
          default: ;
        endcase
      end
      S_SSCAN: begin
        if (sts.bit_used) cmd.scan_step = 1'b1;
        else state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.slot_wr_new = 1'b1;
        if (sts.cur_empty) begin
          state_nxt = S_SUPD;
        end else begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_STRD;
        end
      end
      S_STRD: begin
        cmd.tail_wr = 1'b1;
        state_nxt   = S_SUPD;
      end
      S_SUPD: begin
        cmd.send_upd = 1'b1;
        cmd.set_st   = 1'b1;
        cmd.st       = tmqt_pkg::ST_OK;
        state_nxt    = S_FIN;
      end
      S_RCHK: begin
        priority if (sts.match) begin
          cmd.rcv_hit = 1'b1;
          cmd.set_st  = 1'b1;
          cmd.st      = tmqt_pkg::ST_OK;
          state_nxt   = S_FIN;
        end else if (sts.last) begin
          cmd.set_st = 1'b1;
          cmd.st     = tmqt_pkg::ST_NO_MATCH;
          state_nxt  = S_FIN;
        end else begin
          cmd.rcv_step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/tmqt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmqt_dp
// Queue table, slot bitmaps, message slot store and result register.
// ----------------------------------------------------------------------------
module tmqt_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_mode,
  input  logic [31:0]              in_queue_id,
  input  logic signed [31:0]       in_msg_kind,
  input  logic [31:0]              in_payload_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic [31:0]              out_payload_out,
  output logic signed [31:0]       out_type_out,
  input  tmqt_pkg::dp_cmd_t        cmd,
  output tmqt_pkg::dp_sts_t        sts
);

  localparam int NQ = tmqt_pkg::NUM_QUEUES;
  localparam int NS = tmqt_pkg::MSG_SLOTS;
  localparam int QW = tmqt_pkg::QW;
  localparam int SW = tmqt_pkg::SW;
  localparam int AW = tmqt_pkg::AW;
  localparam int WW = $bits(tmqt_pkg::slot_word_t);
  localparam logic [SW-1:0] CNT_MAX = SW'(NS - 1);

  logic [1:0]         mode_r;
  logic [31:0]        id_r;
  logic signed [31:0] type_r;
  logic [31:0]        data_r;

  logic [NQ-1:0]      in_use_r;
  logic [31:0]        ident_r [NQ];
  logic [SW-1:0]      head_r  [NQ];
  logic [SW-1:0]      tail_r  [NQ];
  logic [SW-1:0]      count_r [NQ];
  logic [NQ-1:0]      row_valid_r;

  logic [QW-1:0]      q_r;
  logic [SW-1:0]      scan_r;
  logic [SW-1:0]      k_r;
  logic [SW-1:0]      cur_r;
  logic [SW-1:0]      prev_r;
  tmqt_pkg::slot_word_t prev_word_r;

  logic [2:0]         res_st_r;
  logic [31:0]        res_pay_r;
  logic signed [31:0] res_typ_r;
  logic               out_valid_r;
  logic [2:0]         out_st_r;
  logic [31:0]        out_pay_r;
  logic signed [31:0] out_typ_r;

  logic [NQ-1:0]      hit_vec;
  logic               hit;
  logic [QW-1:0]      hit_q;
  logic               has_free;
  logic [QW-1:0]      free_q;

  logic               slot_we, slot_re;
  logic [AW-1:0]      slot_waddr, slot_raddr;
  tmqt_pkg::slot_word_t slot_wdata, rword;
  logic [WW-1:0]      slot_rdata;

  logic               row_we;
  logic [NS-1:0]      row_wdata, row_rdata, row_q;

  always_comb begin
    hit      = 1'b0;
    hit_q    = '0;
    has_free = 1'b0;
    free_q   = '0;
    for (int q = NQ - 1; q >= 0; q--) begin
      hit_vec[q] = in_use_r[q] && (ident_r[q] == id_r);
      if (hit_vec[q]) begin
        hit   = 1'b1;
        hit_q = QW'(q);
      end
      if (!in_use_r[q]) begin
        has_free = 1'b1;
        free_q   = QW'(q);
      end
    end
  end

  assign rword = tmqt_pkg::slot_word_t'(slot_rdata);
  assign row_q = row_valid_r[q_r] ? row_rdata : '0;

  assign sts.mode      = mode_r;
  assign sts.hit       = hit;
  assign sts.tbl_full  = !has_free;
  assign sts.type_zero = (type_r == 32'sd0);
  assign sts.q_full    = (count_r[hit_q] == CNT_MAX);
  assign sts.q_empty   = (count_r[hit_q] == '0);
  assign sts.cur_empty = (count_r[q_r] == '0);
  assign sts.bit_used  = row_q[scan_r];
  assign sts.last      = (k_r == count_r[q_r] - SW'(1));
  assign sts.match     = (type_r == 32'sd0) || (rword.typ == type_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // slot store ports
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = {q_r, scan_r};
    slot_wdata = '{typ: type_r, data: data_r, nxt: scan_r};
    if (cmd.slot_wr_new) begin
      slot_we = 1'b1;
    end else if (cmd.tail_wr) begin
      slot_we    = 1'b1;
      slot_waddr = {q_r, tail_r[q_r]};
      slot_wdata = '{typ: rword.typ, data: rword.data, nxt: scan_r};
    end else if (cmd.rcv_hit && (k_r != '0)) begin
      slot_we    = 1'b1;
      slot_waddr = {q_r, prev_r};
      slot_wdata = '{typ: prev_word_r.typ, data: prev_word_r.data, nxt: rword.nxt};
    end
    slot_re    = cmd.recv_start || cmd.rd_tail || cmd.rcv_step;
    slot_raddr = {hit_q, head_r[hit_q]};
    if (cmd.rd_tail) slot_raddr = {q_r, tail_r[q_r]};
    else if (cmd.rcv_step) slot_raddr = {q_r, rword.nxt};
  end

  always_comb begin
    row_we    = cmd.send_upd || cmd.rcv_hit;
    row_wdata = cmd.send_upd ? (row_q | (NS'(1) << scan_r))
                             : (row_q & ~(NS'(1) << cur_r));
  end

  tmqt_ram #(.W(WW), .D(2 ** AW)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  tmqt_ram #(.W(NS), .D(NQ)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (q_r),
    .wdata (row_wdata),
    .re    (cmd.send_start || cmd.recv_start),
    .raddr (hit_q),
    .rdata (row_rdata)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      id_r      <= in_queue_id;
      type_r    <= in_msg_kind;
      data_r    <= in_payload_in;
      res_pay_r <= '0;
      res_typ_r <= '0;
    end
    if (cmd.send_start || cmd.recv_start) begin
      q_r    <= hit_q;
      scan_r <= SW'(1);
      k_r    <= '0;
      cur_r  <= head_r[hit_q];
    end
    if (cmd.scan_step) scan_r <= scan_r + SW'(1);
    if (cmd.rcv_step) begin
      prev_r      <= cur_r;
      prev_word_r <= rword;
      cur_r       <= rword.nxt;
      k_r         <= k_r + SW'(1);
    end
    if (cmd.rcv_hit) begin
      res_pay_r <= rword.data;
      res_typ_r <= rword.typ;
    end
    if (cmd.set_st) res_st_r <= cmd.st;
    if (cmd.create) ident_r[free_q] <= id_r;
    if (cmd.send_upd) begin
      tail_r[q_r] <= scan_r;
      if (count_r[q_r] == '0) head_r[q_r] <= scan_r;
    end
    if (cmd.rcv_hit) begin
      if (k_r == '0) head_r[q_r] <= rword.nxt;
      if (sts.last) tail_r[q_r] <= prev_r;
    end
    if (cmd.out_load) begin
      out_st_r  <= res_st_r;
      out_pay_r <= res_pay_r;
      out_typ_r <= res_typ_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < NQ; q++) count_r[q] <= '0;
    end else begin
      if (cmd.create) begin
        in_use_r[free_q] <= 1'b1;
        count_r[free_q]  <= '0;
      end
      if (cmd.del) begin
        in_use_r[hit_q]    <= 1'b0;
        count_r[hit_q]     <= '0;
        row_valid_r[hit_q] <= 1'b0;
      end
      if (cmd.send_upd) begin
        count_r[q_r]     <= count_r[q_r] + SW'(1);
        row_valid_r[q_r] <= 1'b1;
      end
      if (cmd.rcv_hit) begin
        count_r[q_r]     <= count_r[q_r] - SW'(1);
        row_valid_r[q_r] <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_payload_out = out_pay_r;
  assign out_type_out    = out_typ_r;

  a_send_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_upd |-> count_r[q_r] != CNT_MAX)
    else $error("send into a full queue");

  a_recv_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rcv_hit |-> count_r[q_r] != '0)
    else $error("receive from an empty queue");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> scan_r != CNT_MAX)
    else $error("free slot scan ran off the region");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("result word dropped under stall");

endmodule

// ----- src/typed_message_queue_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_message_queue_table_core
// Table of typed message queues found by 32-bit id: create, delete, send and
// receive by type, one status word per request.
//
// Usage: a request word (mode, queue_id, msg_kind, payload_in) is taken on
// in_valid with in_stall low; one result word (status, payload_out,
// type_out) follows on the out_ channel for every request.
// Requests are handled one at a time; in_stall is high from acceptance until
// the result is moved into the output register.
// Create, delete and rejected requests are decided in the lookup step. Send
// scans past occupied slots to a free one, writes the message there, links it
// behind the old tail if the queue is not empty and updates the queue. Receive
// walks the queue's list from the head to a type match or its last message.
// A waiting result does not block the next request; only a second result
// waits while out_stall holds the first one.
// Reset (rst_n low, synchronous) empties the table; message storage needs no
// clearing pass.
// ----------------------------------------------------------------------------
module typed_message_queue_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_queue_id,
  input  logic signed [31:0] in_msg_kind,
  input  logic [31:0]        in_payload_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_payload_out,
  output logic signed [31:0] out_type_out
);

  tmqt_pkg::dp_cmd_t cmd;
  tmqt_pkg::dp_sts_t sts;

  tmqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmqt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_queue_id     (in_queue_id),
    .in_msg_kind     (in_msg_kind),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_payload_out (out_payload_out),
    .out_type_out    (out_type_out),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
